// File: rtl/smf_pkg.sv
// shared types, constants and byte classification for the track event parser
package smf_pkg;

    localparam logic [7:0] STATUS_BIT   = 8'h80;
    localparam logic [7:0] SYSTEM_BASE  = 8'hF0;
    localparam logic [6:0] DATA_MASK    = 7'h7F;
    localparam logic [7:0] SYSEX_START  = 8'hF0;
    localparam logic [7:0] SYSEX_ESCAPE = 8'hF7;
    localparam logic [7:0] META_STATUS  = 8'hFF;
    localparam logic [7:0] META_EOT     = 8'h2F;
    localparam logic [7:0] META_TEMPO   = 8'h51;
    localparam logic [7:0] PROGRAM_HI   = 8'hC0;
    localparam logic [7:0] PRESSURE_HI  = 8'hD0;

    typedef enum logic [3:0] {
        PH_DELTA   = 4'd0,
        PH_STATUS  = 4'd1,
        PH_DATA1   = 4'd2,
        PH_DATA2   = 4'd3,
        PH_CLASS   = 4'd4,
        PH_LEN     = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_DONE    = 4'd7,
        PH_ERROR   = 4'd8
    } phase_t;

    typedef enum logic [2:0] {
        K_CHAN  = 3'd0,
        K_SYSEX = 3'd1,
        K_TEMPO = 3'd2,
        K_META  = 3'd3,
        K_EOT   = 3'd4,
        K_ERR   = 3'd5,
        K_NONE  = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        E_NONE    = 2'd0,
        E_RUNNING = 2'd1,
        E_TRUNC   = 2'd2,
        E_ILLEGAL = 2'd3
    } err_t;

    // classified track byte, as queued between front and back
    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic       is_data;
        logic       is_chan;
        logic       is_sysex;
        logic       is_meta;
        logic       is_illegal;
    } cmd_t;

    // one finished event
    typedef struct packed {
        kind_t       kind;
        logic [31:0] tick;
        logic [7:0]  status;
        logic [7:0]  first;
        logic [7:0]  second;
        logic [31:0] len;
        logic [23:0] tempo;
        err_t        err;
    } res_t;

    // program change and channel pressure carry a single data byte
    function automatic logic one_data_byte(input logic [7:0] status);
        logic [7:0] hi;
        hi = status & SYSTEM_BASE;
        return (hi == PROGRAM_HI) || (hi == PRESSURE_HI);
    endfunction

endpackage

// File: rtl/smf_front.sv
// front end: classifies incoming track bytes and queues them for the parser
module smf_front
    import smf_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       first_of_track,
    input  logic       last_of_track,
    output logic       cmd_valid,
    output cmd_t       cmd_head,
    input  logic       cmd_take
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t            queue_mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    cmd_t            cls;
    logic            push_fire;
    logic            pop_fire;

    always_comb
    begin
        cls.data       = data_byte;
        cls.first      = first_of_track;
        cls.last       = last_of_track;
        cls.is_data    = (data_byte & STATUS_BIT) == 8'h00;
        cls.is_chan    = ((data_byte & STATUS_BIT) != 8'h00) && (data_byte < SYSTEM_BASE);
        cls.is_sysex   = (data_byte == SYSEX_START) || (data_byte == SYSEX_ESCAPE);
        cls.is_meta    = data_byte == META_STATUS;
        cls.is_illegal = (data_byte >= SYSTEM_BASE) && (data_byte != SYSEX_START)
                         && (data_byte != SYSEX_ESCAPE) && (data_byte != META_STATUS);
    end

    assign full      = count_reg == CW'(DEPTH);
    assign cmd_valid = count_reg != '0;
    assign cmd_head  = queue_mem[rd_ptr_reg];
    assign push_fire = push && !full;
    assign pop_fire  = cmd_take && cmd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_fire && !pop_fire)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_fire && !push_fire)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            queue_mem[wr_ptr_reg] <= cls;
        end
    end

endmodule

// File: rtl/smf_back.sv
// back end: event parser state machine and two-entry result queue
module smf_back
    import smf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  cmd_t cmd_head,
    output logic cmd_take,
    input  logic pop,
    output logic empty,
    output res_t res_head
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  rs_reg, rs_next;
    logic [31:0] tick_reg, tick_next;
    logic [31:0] acc_reg, acc_next;
    logic [7:0]  cur_reg, cur_next;
    logic [7:0]  hf_reg, hf_next;
    logic [7:0]  hs_reg, hs_next;
    logic [31:0] total_reg, total_next;
    logic [31:0] left_reg, left_next;
    logic [23:0] tempo_reg, tempo_next;
    logic [1:0]  pidx_reg, pidx_next;

    // state as seen by this byte, after an optional track restart
    phase_t      e_phase;
    logic [7:0]  e_rs, e_cur, e_hf;
    logic [31:0] e_tick, e_acc, e_total, e_left;
    logic [23:0] e_tempo;
    logic [1:0]  e_pidx;

    logic [7:0]  b;
    logic [31:0] acc_push;
    logic [31:0] left_dec;
    logic [31:0] tick_upd;
    logic [23:0] tempo_upd;
    logic [1:0]  pidx_upd;
    logic        number_end;

    kind_t       kind;
    err_t        err;
    res_t        res;
    logic        res_valid;
    logic        go;

    res_t        res_mem [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg, count_next;
    logic        pop_fire;
    logic        push_fire;
    logic        space;

    function automatic kind_t meta_kind(input logic [7:0] status, input logic [7:0] cls);
        kind_t k;
        if (status != META_STATUS)
        begin
            k = K_SYSEX;
        end
        else if (cls == META_EOT)
        begin
            k = K_EOT;
        end
        else if (cls == META_TEMPO)
        begin
            k = K_TEMPO;
        end
        else
        begin
            k = K_META;
        end
        return k;
    endfunction

    assign pop_fire  = pop && (count_reg != 2'd0);
    assign space     = (count_reg != 2'd2) || pop_fire;
    assign go        = cmd_valid && space;
    assign cmd_take  = go;
    assign push_fire = go && res_valid;
    assign empty     = count_reg == 2'd0;
    assign res_head  = res_mem[rd_ptr_reg];

    always_comb
    begin
        if (cmd_head.first)
        begin
            e_phase = PH_DELTA;
            e_rs    = '0;
            e_cur   = '0;
            e_hf    = '0;
            e_tick  = '0;
            e_acc   = '0;
            e_total = '0;
            e_left  = '0;
            e_tempo = '0;
            e_pidx  = '0;
        end
        else
        begin
            e_phase = phase_reg;
            e_rs    = rs_reg;
            e_cur   = cur_reg;
            e_hf    = hf_reg;
            e_tick  = tick_reg;
            e_acc   = acc_reg;
            e_total = total_reg;
            e_left  = left_reg;
            e_tempo = tempo_reg;
            e_pidx  = pidx_reg;
        end
    end

    assign b          = cmd_head.data;
    assign number_end = cmd_head.is_data;
    assign acc_push   = {e_acc[24:0], b[6:0] & DATA_MASK};
    assign left_dec   = e_left - 32'd1;
    assign tick_upd   = (e_phase == PH_DELTA && number_end) ? e_tick + acc_push : e_tick;
    assign pidx_upd   = (e_pidx != 2'd3) ? e_pidx + 2'd1 : e_pidx;

    always_comb
    begin
        case (e_pidx)
            2'd0:    tempo_upd = e_tempo | {b, 16'h0000};
            2'd1:    tempo_upd = e_tempo | {8'h00, b, 8'h00};
            2'd2:    tempo_upd = e_tempo | {16'h0000, b};
            default: tempo_upd = e_tempo;
        endcase
    end

    // result of this byte
    always_comb
    begin
        kind       = K_NONE;
        err        = E_NONE;
        res.kind   = K_NONE;
        res.tick   = tick_upd;
        res.status = e_cur;
        res.first  = e_hf;
        res.second = 8'h00;
        res.len    = 32'd0;
        res.tempo  = 24'h000000;
        res.err    = E_NONE;
        case (e_phase)
            PH_DELTA, PH_CLASS, PH_DONE, PH_ERROR:
            begin
                kind = K_NONE;
            end
            PH_STATUS:
            begin
                res.first = b;
                if (cmd_head.is_data)
                begin
                    if (e_rs == 8'h00)
                    begin
                        err = E_RUNNING;
                    end
                    else if (one_data_byte(e_rs))
                    begin
                        kind       = K_CHAN;
                        res.status = e_rs;
                        res.len    = 32'd2;
                    end
                end
                else if (cmd_head.is_illegal)
                begin
                    err = E_ILLEGAL;
                end
            end
            PH_DATA1:
            begin
                res.first = b;
                if (one_data_byte(e_cur))
                begin
                    kind    = K_CHAN;
                    res.len = 32'd2;
                end
            end
            PH_DATA2:
            begin
                kind       = K_CHAN;
                res.second = b;
                res.len    = 32'd3;
            end
            PH_LEN:
            begin
                if (number_end && acc_push == 32'd0)
                begin
                    kind = meta_kind(e_cur, e_hf);
                end
            end
            default:
            begin
                if (left_dec == 32'd0)
                begin
                    kind      = meta_kind(e_cur, e_hf);
                    res.len   = e_total;
                    res.tempo = tempo_upd;
                end
            end
        endcase

        // truncated track
        if (err == E_NONE && cmd_head.last && kind != K_EOT &&
            e_phase != PH_DONE && e_phase != PH_ERROR)
        begin
            err = E_TRUNC;
        end

        res.kind = kind;
        if (kind != K_CHAN)
        begin
            res.second = 8'h00;
        end
        if (kind == K_SYSEX)
        begin
            res.first = 8'h00;
        end
        if (kind != K_TEMPO)
        begin
            res.tempo = 24'h000000;
        end
        if (err != E_NONE)
        begin
            res.kind   = K_ERR;
            res.status = 8'h00;
            res.first  = 8'h00;
            res.second = 8'h00;
            res.len    = 32'd0;
            res.tempo  = 24'h000000;
            res.err    = err;
        end
        res_valid = (err != E_NONE) || (kind != K_NONE);
    end

    // parser state update
    always_comb
    begin
        phase_next = phase_reg;
        rs_next    = rs_reg;
        tick_next  = tick_reg;
        acc_next   = acc_reg;
        cur_next   = cur_reg;
        hf_next    = hf_reg;
        hs_next    = hs_reg;
        total_next = total_reg;
        left_next  = left_reg;
        tempo_next = tempo_reg;
        pidx_next  = pidx_reg;
        if (go)
        begin
            phase_next = e_phase;
            rs_next    = e_rs;
            tick_next  = tick_upd;
            acc_next   = e_acc;
            cur_next   = e_cur;
            hf_next    = e_hf;
            hs_next    = cmd_head.first ? 8'h00 : hs_reg;
            total_next = e_total;
            left_next  = e_left;
            tempo_next = e_tempo;
            pidx_next  = e_pidx;
            case (e_phase)
                PH_DONE, PH_ERROR:
                begin
                    phase_next = e_phase;
                end
                PH_DELTA:
                begin
                    acc_next = number_end ? 32'd0 : acc_push;
                    if (number_end)
                    begin
                        phase_next = PH_STATUS;
                    end
                end
                PH_STATUS:
                begin
                    hf_next    = 8'h00;
                    hs_next    = 8'h00;
                    total_next = 32'd0;
                    left_next  = 32'd0;
                    tempo_next = 24'h000000;
                    pidx_next  = 2'd0;
                    if (cmd_head.is_data)
                    begin
                        if (e_rs != 8'h00)
                        begin
                            cur_next = e_rs;
                            hf_next  = b;
                            if (!one_data_byte(e_rs))
                            begin
                                phase_next = PH_DATA2;
                            end
                        end
                    end
                    else if (cmd_head.is_chan)
                    begin
                        rs_next    = b;
                        cur_next   = b;
                        phase_next = PH_DATA1;
                    end
                    else if (cmd_head.is_sysex)
                    begin
                        cur_next   = b;
                        phase_next = PH_LEN;
                    end
                    else if (cmd_head.is_meta)
                    begin
                        cur_next   = b;
                        phase_next = PH_CLASS;
                    end
                end
                PH_DATA1:
                begin
                    hf_next = b;
                    if (!one_data_byte(e_cur))
                    begin
                        phase_next = PH_DATA2;
                    end
                end
                PH_DATA2:
                begin
                    hs_next = b;
                end
                PH_CLASS:
                begin
                    hf_next    = b;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    acc_next = number_end ? 32'd0 : acc_push;
                    if (number_end)
                    begin
                        total_next = acc_push;
                        left_next  = acc_push;
                        if (acc_push != 32'd0)
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                default:
                begin
                    tempo_next = tempo_upd;
                    pidx_next  = pidx_upd;
                    left_next  = left_dec;
                end
            endcase
            if (err != E_NONE)
            begin
                phase_next = PH_ERROR;
            end
            else if (kind == K_EOT)
            begin
                phase_next = PH_DONE;
            end
            else if (kind != K_NONE)
            begin
                phase_next = PH_DELTA;
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (push_fire && !pop_fire)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop_fire && !push_fire)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_DELTA;
            rs_reg     <= '0;
            tick_reg   <= '0;
            acc_reg    <= '0;
            cur_reg    <= '0;
            hf_reg     <= '0;
            hs_reg     <= '0;
            total_reg  <= '0;
            left_reg   <= '0;
            tempo_reg  <= '0;
            pidx_reg   <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            rs_reg     <= rs_next;
            tick_reg   <= tick_next;
            acc_reg    <= acc_next;
            cur_reg    <= cur_next;
            hf_reg     <= hf_next;
            hs_reg     <= hs_next;
            total_reg  <= total_next;
            left_reg   <= left_next;
            tempo_reg  <= tempo_next;
            pidx_reg   <= pidx_next;
            count_reg  <= count_next;
            if (push_fire)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop_fire)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            res_mem[wr_ptr_reg] <= res;
        end
    end

endmodule

// File: rtl/smf_track_event_parser.sv
// top level of the midi file track event parser
//
// input channel: one track byte per request, with first_of_track and
// last_of_track flags; a request is taken on a rising edge with push high
// and full low
// result channel: one finished event per request; the oldest event sits on
// the result ports while empty is low and leaves on an edge with pop high
// a taken byte is first written into the front queue, then parsed and its
// event written into the result queue, after which empty can fall
// throughput: one byte per cycle while the result queue has room, set by the
// parser update in the back end; most bytes give no event
// the front queue (CMD_QUEUE_DEPTH requests) and the two-entry result queue
// let either side stall: when pop stays low the result queue fills, the
// parser stops, the front queue fills and full rises
// reset clears all queues and parser state; the parser waits for a delta
// time with tick zero and no running status
// errors latch the parser until a byte flagged first_of_track arrives
module smf_track_event_parser
    import smf_pkg::*;
#(
    parameter int CMD_QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        first_of_track,
    input  logic        last_of_track,
    input  logic        pop,
    output logic        empty,
    output logic [2:0]  event_kind,
    output logic [31:0] event_tick,
    output logic [7:0]  status_byte,
    output logic [7:0]  first_data,
    output logic [7:0]  second_data,
    output logic [31:0] event_length,
    output logic [23:0] tempo_value,
    output logic [1:0]  error_code
);

    logic cmd_valid;
    logic cmd_take;
    cmd_t cmd_head;
    res_t res_head;

    // classify and queue raw bytes
    smf_front #(
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .data_byte      (data_byte),
        .first_of_track (first_of_track),
        .last_of_track  (last_of_track),
        .cmd_valid      (cmd_valid),
        .cmd_head       (cmd_head),
        .cmd_take       (cmd_take)
    );

    // parse and buffer finished events
    smf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_head  (cmd_head),
        .cmd_take  (cmd_take),
        .pop       (pop),
        .empty     (empty),
        .res_head  (res_head)
    );

    // unpack the head result onto the ports
    assign event_kind   = res_head.kind;
    assign event_tick   = res_head.tick;
    assign status_byte  = res_head.status;
    assign first_data   = res_head.first;
    assign second_data  = res_head.second;
    assign event_length = res_head.len;
    assign tempo_value  = res_head.tempo;
    assign error_code   = res_head.err;

    // error code present exactly on error events
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((event_kind == K_ERR) == (error_code != E_NONE)))
        else $error("error code does not match event kind");

    // channel events are two or three bytes long
    a_chan_len: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && event_kind == K_CHAN) |-> (event_length == 32'd2 || event_length == 32'd3))
        else $error("channel event with bad length");

    // tempo only reported on tempo meta events
    a_tempo: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && event_kind != K_TEMPO) |-> (tempo_value == 24'h000000))
        else $error("tempo value on non tempo event");

    // a held result stays put while the receiver stalls
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(event_kind) && $stable(event_tick)))
        else $error("result changed while stalled");

endmodule

// File: verif/tb_smf_track_event_parser.sv
// testbench for the midi file track event parser: directed tracks, backpressure and random tracks
module tb_smf_track_event_parser;
    import smf_pkg::*;

    // generous ceiling; a correct run needs a small fraction of this
    localparam int CYCLE_LIMIT = 300000;
    // cycles allowed after the last expected event for stray results to show
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS = 10;

    typedef logic [7:0] byte_list_t[$];

    // one byte request as it goes to the block
    typedef struct {
        logic [7:0] data;
        logic       first;
        logic       last;
    } track_byte_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  data_byte;
    logic        first_of_track;
    logic        last_of_track;
    logic        pop;
    logic        empty;
    logic [2:0]  event_kind;
    logic [31:0] event_tick;
    logic [7:0]  status_byte;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [31:0] event_length;
    logic [23:0] tempo_value;
    logic [1:0]  error_code;

    smf_track_event_parser dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .data_byte      (data_byte),
        .first_of_track (first_of_track),
        .last_of_track  (last_of_track),
        .pop            (pop),
        .empty          (empty),
        .event_kind     (event_kind),
        .event_tick     (event_tick),
        .status_byte    (status_byte),
        .first_data     (first_data),
        .second_data    (second_data),
        .event_length   (event_length),
        .tempo_value    (tempo_value),
        .error_code     (error_code)
    );

    // events predicted from accepted bytes, oldest first
    res_t        expected_events[$];
    // bytes of the track being assembled for sending
    track_byte_t track_bytes[$];

    int mismatches    = 0;
    int counted_bytes = 0;   // accepted bytes the parser actually consumed
    int cycle_count   = 0;
    int pop_hold      = 0;   // receiver hold-off, counted down by the receiver
    bit gaps_enabled  = 1'b1;

    // running status as seen by the track generator, so it can emit running data
    logic [7:0] draft_running;

    // parser state mirrored by the predictor
    phase_t      trk_phase;
    logic [7:0]  trk_running;
    logic [31:0] trk_tick;
    logic [31:0] trk_number;
    logic [7:0]  trk_status;
    logic [7:0]  trk_first;
    logic [7:0]  trk_second;
    logic [31:0] trk_total;
    logic [31:0] trk_left;
    logic [23:0] trk_tempo;
    logic [1:0]  trk_index;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // program change and channel pressure are the two-byte channel messages
    function automatic bit takes_one_data(logic [7:0] status);
        return status[7:4] == PROGRAM_HI[7:4] || status[7:4] == PRESSURE_HI[7:4];
    endfunction

    function automatic void clear_parser();
        trk_phase   = PH_DELTA;
        trk_running = '0;
        trk_tick    = '0;
        trk_number  = '0;
        trk_status  = '0;
        trk_first   = '0;
        trk_second  = '0;
        trk_total   = '0;
        trk_left    = '0;
        trk_tempo   = '0;
        trk_index   = '0;
    endfunction

    // kind of a finished sysex or meta event
    function automatic kind_t finished_kind();
        if (trk_status != META_STATUS)
            return K_SYSEX;
        if (trk_first == META_EOT)
            return K_EOT;
        if (trk_first == META_TEMPO)
            return K_TEMPO;
        return K_META;
    endfunction

    // advances the mirrored parser by one byte and queues the event it
    // finishes, if any; returns 0 when the byte was ignored
    function automatic bit parse_track_byte(logic [7:0] b, logic first_flag, logic last_flag);
        kind_t       kind;
        err_t        err;
        logic [31:0] len;
        res_t        ev;
        kind = K_NONE;
        err  = E_NONE;
        len  = '0;
        ev   = '0;
        if (first_flag)
            clear_parser();
        // ended or latched tracks swallow everything until the next start
        if (trk_phase == PH_DONE || trk_phase == PH_ERROR)
            return 1'b0;
        case (trk_phase)
            PH_DELTA:
            begin
                trk_number = {trk_number[24:0], b[6:0]};
                if (!b[7])
                begin
                    trk_tick   = trk_tick + trk_number;
                    trk_number = '0;
                    trk_phase  = PH_STATUS;
                end
            end
            PH_STATUS:
            begin
                trk_first  = '0;
                trk_second = '0;
                trk_total  = '0;
                trk_left   = '0;
                trk_tempo  = '0;
                trk_index  = '0;
                if (!b[7])
                begin
                    // data byte here means running status
                    if (trk_running == '0)
                        err = E_RUNNING;
                    else
                    begin
                        trk_status = trk_running;
                        trk_first  = b;
                        if (takes_one_data(trk_status))
                        begin
                            kind = K_CHAN;
                            len  = 32'd2;
                        end
                        else
                            trk_phase = PH_DATA2;
                    end
                end
                else if (b < SYSTEM_BASE)
                begin
                    trk_running = b;
                    trk_status  = b;
                    trk_phase   = PH_DATA1;
                end
                else if (b == SYSEX_START || b == SYSEX_ESCAPE)
                begin
                    trk_status = b;
                    trk_phase  = PH_LEN;
                end
                else if (b == META_STATUS)
                begin
                    trk_status = b;
                    trk_phase  = PH_CLASS;
                end
                else
                    err = E_ILLEGAL;
            end
            PH_DATA1:
            begin
                trk_first = b;
                if (takes_one_data(trk_status))
                begin
                    kind = K_CHAN;
                    len  = 32'd2;
                end
                else
                    trk_phase = PH_DATA2;
            end
            PH_DATA2:
            begin
                trk_second = b;
                kind       = K_CHAN;
                len        = 32'd3;
            end
            PH_CLASS:
            begin
                trk_first = b;
                trk_phase = PH_LEN;
            end
            PH_LEN:
            begin
                trk_number = {trk_number[24:0], b[6:0]};
                if (!b[7])
                begin
                    trk_total  = trk_number;
                    trk_left   = trk_number;
                    trk_number = '0;
                    if (trk_total == '0)
                    begin
                        kind = finished_kind();
                        len  = '0;
                    end
                    else
                        trk_phase = PH_PAYLOAD;
                end
            end
            default:
            begin
                // first three payload bytes land big-endian in the tempo word
                case (trk_index)
                    2'd0: trk_tempo[23:16] = b;
                    2'd1: trk_tempo[15:8]  = b;
                    2'd2: trk_tempo[7:0]   = b;
                    default: ;
                endcase
                if (trk_index != 2'd3)
                    trk_index++;
                trk_left = trk_left - 32'd1;
                if (trk_left == '0)
                begin
                    kind = finished_kind();
                    len  = trk_total;
                end
            end
        endcase

        // a track may only end on the byte that completes end of track
        if (err == E_NONE && last_flag && kind != K_EOT)
            err = E_TRUNC;

        if (err != E_NONE)
        begin
            trk_phase = PH_ERROR;
            ev.kind   = K_ERR;
            ev.tick   = trk_tick;
            ev.err    = err;
            expected_events.push_back(ev);
        end
        else if (kind != K_NONE)
        begin
            trk_phase = (kind == K_EOT) ? PH_DONE : PH_DELTA;
            ev.kind   = kind;
            ev.tick   = trk_tick;
            ev.status = trk_status;
            ev.first  = (kind == K_SYSEX) ? 8'h00 : trk_first;
            ev.second = (kind == K_CHAN) ? trk_second : 8'h00;
            ev.len    = len;
            ev.tempo  = (kind == K_TEMPO) ? trk_tempo : 24'h0;
            ev.err    = E_NONE;
            expected_events.push_back(ev);
        end
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // result side: random pop with hold-off, checked on every accepted event
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (pop_hold > 0)
        begin
            pop <= 1'b0;
            pop_hold--;
        end
        else
            pop <= !(gaps_enabled && $urandom_range(99) < 18);
    end

    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        if (rst_n && pop && !empty)
        begin
            got.kind   = kind_t'(event_kind);
            got.tick   = event_tick;
            got.status = status_byte;
            got.first  = first_data;
            got.second = second_data;
            got.len    = event_length;
            got.tempo  = tempo_value;
            got.err    = err_t'(error_code);
            if (expected_events.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $write("unexpected event: kind %0d tick %h status %h data %h %h",
                           got.kind, got.tick, got.status, got.first, got.second);
                    $display(" len %h tempo %h err %0d", got.len, got.tempo, got.err);
                end
            end
            else
            begin
                want = expected_events.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("event mismatch at cycle %0d", cycle_count);
                        $write("  expected: kind %0d tick %h status %h data %h %h",
                               want.kind, want.tick, want.status, want.first, want.second);
                        $display(" len %h tempo %h err %0d", want.len, want.tempo, want.err);
                        $write("  actual:   kind %0d tick %h status %h data %h %h",
                               got.kind, got.tick, got.status, got.first, got.second);
                        $display(" len %h tempo %h err %0d", got.len, got.tempo, got.err);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // called at a falling edge; returns at the falling edge after acceptance
    // with push still high, so back-to-back bytes need no idle gap between them
    task automatic send_byte(track_byte_t tb);
        while (gaps_enabled && $urandom_range(99) < 18)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push           <= 1'b1;
        data_byte      <= tb.data;
        first_of_track <= tb.first;
        last_of_track  <= tb.last;
        do
            @(posedge clk);
        while (full);
        if (parse_track_byte(tb.data, tb.first, tb.last))
            counted_bytes++;
        @(negedge clk);
    endtask

    task automatic send_track();
        foreach (track_bytes[i])
            send_byte(track_bytes[i]);
        track_bytes.delete();
    endtask

    task automatic release_push();
        push <= 1'b0;
        @(negedge clk);
    endtask

    // sender pause until every predicted event has been popped
    task automatic wait_for_drain();
        release_push();
        while (expected_events.size() != 0)
            @(negedge clk);
    endtask

    // directed track: flags only on the head and tail bytes
    task automatic send_directed(byte_list_t list, logic first_flag, logic last_flag);
        track_byte_t tb;
        foreach (list[i])
        begin
            tb.data  = list[i];
            tb.first = (i == 0) ? first_flag : 1'b0;
            tb.last  = (i == list.size() - 1) ? last_flag : 1'b0;
            track_bytes.push_back(tb);
        end
        send_track();
    endtask

    // ------------------------------------------------------------------
    // random track generation
    // ------------------------------------------------------------------

    function automatic void add_byte(logic [7:0] b);
        track_byte_t tb;
        tb.data  = b;
        tb.first = 1'b0;
        tb.last  = 1'b0;
        track_bytes.push_back(tb);
    endfunction

    // variable-length number, now and then with a redundant leading zero group
    function automatic void add_number(logic [27:0] value);
        logic [7:0] groups[$];
        groups.push_front({1'b0, value[6:0]});
        value = value >> 7;
        while (value != '0)
        begin
            groups.push_front({1'b1, value[6:0]});
            value = value >> 7;
        end
        if ($urandom_range(99) < 5)
            groups.push_front(STATUS_BIT);
        foreach (groups[i])
            add_byte(groups[i]);
    endfunction

    function automatic void add_delta();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40)
            add_number('0);
        else if (pick < 80)
            add_number(28'($urandom_range(1, 127)));
        else if (pick < 92)
            add_number(28'($urandom_range(128, 16383)));
        else if (pick < 97)
            add_number(28'($urandom));
        else
        begin
            // five-byte delta, overflows the 32-bit accumulation
            repeat (4)
                add_byte(8'($urandom_range(255)) | STATUS_BIT);
            add_byte(8'($urandom_range(127)));
        end
    endfunction

    // byte count plus payload of a sysex or meta event
    function automatic void add_payload(int count);
        add_number(28'(count));
        repeat (count)
            add_byte(8'($urandom_range(255)));
    endfunction

    function automatic int payload_size();
        return ($urandom_range(99) < 90) ? $urandom_range(0, 6) : $urandom_range(7, 150);
    endfunction

    function automatic void add_random_event();
        int         pick;
        logic [7:0] s;
        logic [7:0] cls;
        add_delta();
        pick = $urandom_range(99);
        if (pick < 30 || (pick < 50 && draft_running == '0))
        begin
            s = 8'($urandom_range(8'h80, 8'hEF));
            draft_running = s;
            add_byte(s);
            add_byte(8'($urandom_range(255)));
            if (!takes_one_data(s))
                add_byte(8'($urandom_range(255)));
        end
        else if (pick < 50)
        begin
            // running status: first data byte must look like data
            add_byte(8'($urandom_range(127)));
            if (!takes_one_data(draft_running))
                add_byte(8'($urandom_range(255)));
        end
        else if (pick < 65)
        begin
            add_byte((pick < 58) ? SYSEX_START : SYSEX_ESCAPE);
            add_payload(payload_size());
        end
        else if (pick < 80)
        begin
            add_byte(META_STATUS);
            add_byte(META_TEMPO);
            add_payload(($urandom_range(99) < 60) ? 3 : $urandom_range(0, 5));
        end
        else
        begin
            cls = 8'($urandom_range(255));
            if (cls == META_EOT)
                cls = 8'h01;
            add_byte(META_STATUS);
            add_byte(cls);
            add_payload(payload_size());
        end
    endfunction

    function automatic void add_end_of_track();
        add_delta();
        add_byte(META_STATUS);
        add_byte(META_EOT);
        add_payload(($urandom_range(99) < 85) ? 0 : $urandom_range(1, 3));
    endfunction

    // mostly well-formed tracks with random content; the rest broken or noise
    function automatic void build_random_track(int max_events);
        int          flavor;
        int          cut;
        logic [7:0]  bad;
        track_byte_t tb;
        track_bytes.delete();
        draft_running = '0;
        flavor = $urandom_range(99);
        if (flavor < 5)
        begin
            // raw noise with random flags
            repeat ($urandom_range(1, 20))
            begin
                tb.data  = 8'($urandom_range(255));
                tb.first = ($urandom_range(99) < 10);
                tb.last  = ($urandom_range(99) < 10);
                track_bytes.push_back(tb);
            end
            return;
        end
        if (flavor < 10)
        begin
            // data byte where a status must come, no running status yet
            add_delta();
            add_byte(8'($urandom_range(127)));
        end
        repeat ($urandom_range(1, max_events))
            add_random_event();
        if (flavor >= 10 && flavor < 15)
        begin
            bad = 8'($urandom_range(8'hF1, 8'hFE));
            if (bad == SYSEX_ESCAPE)
                bad = 8'hF1;
            add_delta();
            add_byte(bad);
        end
        add_end_of_track();
        track_bytes[0].first = (flavor < 25 || flavor >= 28);
        if (flavor >= 15 && flavor < 25)
        begin
            // track chunk ends early
            cut = $urandom_range(0, track_bytes.size() - 1);
            track_bytes = track_bytes[0:cut];
        end
        track_bytes[track_bytes.size() - 1].last = 1'b1;
        if (flavor >= 28 && flavor < 32)
        begin
            // stray bytes after the end of the track
            repeat ($urandom_range(1, 5))
                add_byte(8'($urandom_range(255)));
        end
        if (flavor >= 32 && flavor < 35)
        begin
            // restart in the middle of an event
            cut = $urandom_range(0, track_bytes.size() - 1);
            track_bytes[cut].first = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // every channel message length, running status, multi-byte deltas
    task automatic test_channel_events();
        send_directed('{8'h00, 8'h90, 8'h3C, 8'h7F,
                        8'h00, 8'h3C, 8'h00,
                        8'h81, 8'h00, 8'hC5, 8'h10,
                        8'h00, 8'hD0, 8'h7F,
                        8'h7F, 8'hE0, 8'h00, 8'h7F,
                        8'h00, 8'h80, 8'hFF, 8'h80,
                        8'h00, 8'hFF, 8'h2F, 8'h00}, 1'b1, 1'b1);
    endtask

    // tempo with payloads of zero, one, three and four bytes, sysex of both
    // kinds, plain meta, running status surviving sysex and meta, largest
    // four-byte delta, end of track with payload
    task automatic test_meta_and_sysex();
        send_directed('{8'h00, 8'h90, 8'h40, 8'h40,
                        8'h00, 8'hFF, 8'h51, 8'h03, 8'h07, 8'hA1, 8'h20,
                        8'h00, 8'hF0, 8'h02, 8'h43, 8'hF7,
                        8'h00, 8'h40, 8'h7F,
                        8'h00, 8'hFF, 8'h51, 8'h01, 8'hAA,
                        8'h00, 8'hFF, 8'h51, 8'h00,
                        8'h00, 8'hFF, 8'h51, 8'h04, 8'h01, 8'h02, 8'h03, 8'h04,
                        8'h00, 8'hF7, 8'h00,
                        8'h00, 8'hF0, 8'h80, 8'h02, 8'h11, 8'h22,
                        8'h00, 8'hFF, 8'h03, 8'h00,
                        8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hFF, 8'h7F, 8'h00,
                        8'h00, 8'hFF, 8'h2F, 8'h01, 8'h00}, 1'b1, 1'b1);
    endtask

    task automatic test_error_cases();
        // missing running status, then latched until the next start
        send_directed('{8'h00, 8'h40}, 1'b1, 1'b0);
        send_directed('{8'h90, 8'h3C}, 1'b0, 1'b0);
        // illegal status bytes, alone and on the final byte
        send_directed('{8'h00, 8'hF1}, 1'b1, 1'b0);
        send_directed('{8'h00, 8'hFE}, 1'b1, 1'b0);
        send_directed('{8'h00, 8'hF5}, 1'b1, 1'b1);
        // missing running status wins over truncation
        send_directed('{8'h00, 8'h40}, 1'b1, 1'b1);
        // a finished channel event on the last byte is still truncation
        send_directed('{8'h00, 8'h90, 8'h3C, 8'h40}, 1'b1, 1'b1);
        // track that is one unfinished delta byte
        send_directed('{8'h81}, 1'b1, 1'b1);
        // end of track cut off on its class byte
        send_directed('{8'h00, 8'hC0, 8'h05, 8'h00, 8'hFF, 8'h2F}, 1'b1, 1'b1);
        // five-byte delta and a five-byte count that wraps to three
        send_directed('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F,
                        8'hF0, 8'h90, 8'h80, 8'h80, 8'h80, 8'h03, 8'h01, 8'h02, 8'h03,
                        8'h00, 8'hFF, 8'h2F, 8'h00}, 1'b1, 1'b1);
        // huge count, track ends inside the payload
        send_directed('{8'h00, 8'hF7, 8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hAA, 8'hBB},
                      1'b1, 1'b1);
        // bytes after end of track are ignored, the last flag too
        send_directed('{8'h00, 8'hFF, 8'h2F, 8'h00}, 1'b1, 1'b0);
        send_directed('{8'h90, 8'h3C, 8'h40, 8'hFF}, 1'b0, 1'b1);
        // restart mid-event clears tick and running status
        send_directed('{8'h05, 8'h90, 8'h3C}, 1'b1, 1'b0);
        send_directed('{8'h00, 8'h3C}, 1'b1, 1'b0);
        send_directed('{8'h00, 8'hFF, 8'h2F, 8'h00}, 1'b1, 1'b1);
    endtask

    // receiver stalls long enough for both queues to fill and full to rise;
    // the sender keeps offering throughout, then waits for everything
    task automatic test_result_stall();
        pop_hold = 300;
        track_bytes.delete();
        draft_running = '0;
        repeat (30)
            add_random_event();
        add_end_of_track();
        track_bytes[0].first = 1'b1;
        track_bytes[track_bytes.size() - 1].last = 1'b1;
        send_track();
        wait_for_drain();
    endtask

    // back-to-back on both sides
    task automatic test_quiet_stretch();
        gaps_enabled = 1'b0;
        repeat (4)
        begin
            build_random_track(10);
            send_track();
        end
        wait_for_drain();
        gaps_enabled = 1'b1;
    endtask

    task automatic test_random_tracks(int target);
        int start;
        start = counted_bytes;
        while (counted_bytes - start < target)
        begin
            build_random_track(12);
            send_track();
            if ($urandom_range(99) < 5)
                wait_for_drain();
        end
        release_push();
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n          = 1'b0;
        push           = 1'b0;
        data_byte      = '0;
        first_of_track = 1'b0;
        last_of_track  = 1'b0;
        clear_parser();
        repeat (2)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_channel_events();
        test_meta_and_sysex();
        test_error_cases();
        test_result_stall();
        test_quiet_stretch();
        test_random_tracks(400);

        // everything sent: wait out the remaining events plus a margin
        while (expected_events.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);

        if (mismatches == 0 && expected_events.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: files.f
rtl/smf_pkg.sv
rtl/smf_front.sv
rtl/smf_back.sv
rtl/smf_track_event_parser.sv
verif/tb_smf_track_event_parser.sv
